// ----- hw/rtl/tfn_pkg.sv -----
package tfn_pkg;

  // Fraction bits of the unit normal (Q1.NormFracBits).
  localparam int unsigned NormFracBits = 14;

  localparam int unsigned PosW   = 16;
  localparam int unsigned EdgeW  = PosW + 1;
  localparam int unsigned ProdW  = 2 * EdgeW;
  localparam int unsigned CrossW = ProdW + 1;
  localparam int unsigned MagW   = CrossW;
  localparam int unsigned SqW    = 2 * MagW;
  localparam int unsigned SumW   = SqW + 2;
  localparam int unsigned WideW  = SumW + 2 * NormFracBits + 2;
  localparam int unsigned QuotW  = NormFracBits + 1;
  localparam int unsigned CntW   = 6;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CROSS,
    ST_SQLOAD,
    ST_SQ,
    ST_CHECK,
    ST_NLOAD,
    ST_NCAND,
    ST_NTEST
  } tfn_state_e;

  // Emit is kept apart so the enum stays within three bits plus one.
  typedef enum logic {
    OUT_IDLE,
    OUT_BUSY
  } tfn_out_e;

endpackage

// ----- hw/rtl/tfn_vtx_if.sv -----
interface tfn_vtx_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] pos_x;
  logic signed [15:0] pos_y;
  logic signed [15:0] pos_z;
  logic signed [15:0] pos_f;
  logic signed [15:0] tex_u;
  logic signed [15:0] tex_v;
  logic               end_of_mesh;

  modport source (output valid, pos_x, pos_y, pos_z, pos_f, tex_u, tex_v, end_of_mesh,
                  input ready);
  modport sink (input valid, pos_x, pos_y, pos_z, pos_f, tex_u, tex_v, end_of_mesh,
                output ready);
endinterface

// ----- hw/rtl/tfn_res_if.sv -----
interface tfn_res_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] out_x;
  logic signed [15:0] out_y;
  logic signed [15:0] out_z;
  logic signed [15:0] out_f;
  logic signed [15:0] out_u;
  logic signed [15:0] out_v;
  logic signed [15:0] normal_x;
  logic signed [15:0] normal_y;
  logic signed [15:0] normal_z;
  logic               degenerate;
  logic               last_of_run;

  modport source (output valid, out_x, out_y, out_z, out_f, out_u, out_v, normal_x,
                  normal_y, normal_z, degenerate, last_of_run, input ready);
  modport sink (input valid, out_x, out_y, out_z, out_f, out_u, out_v, normal_x,
                normal_y, normal_z, degenerate, last_of_run, output ready);
endinterface

// ----- hw/rtl/triangle_face_normal_unit.sv -----
// A vertex that is only held is stored. A third vertex starts the cross product, the
// squaring of each component, a check, then the bit-by-bit normalisation of each one,
// before the three results; a zero cross product skips normalisation. Throughput is one
// request per cycle while only holding and no results are pending; the shared adder sets
// the triangle cost. Reset (asynchronous, active low) empties the held vertices.
module triangle_face_normal_unit
  import tfn_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  tfn_vtx_if.sink   vtx_i,
  tfn_res_if.source res_o
);

  tfn_state_e state_q, state_d;
  tfn_out_e   ostate_q, ostate_d;

  // Vertex slots: the two held ones and the one that closes a triangle.
  logic signed [PosW-1:0] pos_q  [3][3];
  logic signed [PosW-1:0] attr_q [3][3];
  logic [1:0]             held_q;

  logic [CntW-1:0]          cnt_q;
  logic [1:0]               j_q;
  logic [1:0]               n_q;
  logic signed [CrossW-1:0] c_q   [3];
  logic [SqW-1:0]           csq_q [3];
  logic [SqW-1:0]           mand_q;
  logic [MagW-1:0]          mplr_q;
  logic [SqW-1:0]           acc_q;
  logic [SumW-1:0]          s_q;
  logic [WideW-1:0]         p_q, qs_q, ss_q, cand_q, lim_q;
  logic [QuotW-1:0]         quo_q;
  logic [PosW-1:0]          nrm_q [3];
  logic                     deg_q;

  logic in_fire, out_fire;
  assign in_fire  = vtx_i.valid && vtx_i.ready;
  assign out_fire = res_o.valid && res_o.ready;

  // Edge vectors straight from the slot registers.
  logic signed [EdgeW-1:0] e1 [3];
  logic signed [EdgeW-1:0] e2 [3];
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      e1[i] = EdgeW'(pos_q[1][i]) - EdgeW'(pos_q[0][i]);
      e2[i] = EdgeW'(pos_q[2][i]) - EdgeW'(pos_q[0][i]);
    end
  end

  // One shared 17 x 17 multiplier walks the six cross product terms.
  logic [1:0] ia, ib;
  always_comb begin
    case (cnt_q[2:0])
      3'd0:    begin ia = 2'd1; ib = 2'd2; end
      3'd1:    begin ia = 2'd2; ib = 2'd1; end
      3'd2:    begin ia = 2'd2; ib = 2'd0; end
      3'd3:    begin ia = 2'd0; ib = 2'd2; end
      3'd4:    begin ia = 2'd0; ib = 2'd1; end
      3'd5:    begin ia = 2'd1; ib = 2'd0; end
      default: begin ia = 2'd0; ib = 2'd0; end
    endcase
  end

  logic signed [ProdW-1:0] prod;
  assign prod = e1[ia] * e2[ib];

  logic signed [CrossW-1:0] c_sel;
  logic [MagW-1:0]          c_mag;
  assign c_sel = c_q[j_q];
  assign c_mag = c_sel[CrossW-1] ? MagW'(-c_sel) : MagW'(c_sel);

  logic [SqW-1:0] acc_nxt;
  assign acc_nxt = acc_q + (mplr_q[0] ? mand_q : '0);

  logic [WideW-1:0] qs_add;
  assign qs_add = qs_q + ((cand_q <= lim_q) ? (ss_q << 1) : '0);

  logic [31:0] quo_ext, quo_fin;
  logic [QuotW-1:0] quo_set;
  assign quo_set = quo_q | ((cand_q <= lim_q) ? (QuotW'(1) << cnt_q) : '0);
  assign quo_ext = 32'(quo_set);
  assign quo_fin = c_sel[CrossW-1] ? (32'd0 - quo_ext) : quo_ext;

  // Next state of the arithmetic sequencer.
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE:   if (in_fire && held_q == 2'd2) state_d = ST_CROSS;
      ST_CROSS:  if (cnt_q == CntW'(5)) state_d = ST_SQLOAD;
      ST_SQLOAD: state_d = ST_SQ;
      ST_SQ: begin
        if (cnt_q == CntW'(MagW - 1)) state_d = (j_q == 2'd2) ? ST_CHECK : ST_SQLOAD;
      end
      ST_CHECK:  state_d = (s_q == '0) ? ST_IDLE : ST_NLOAD;
      ST_NLOAD:  state_d = ST_NCAND;
      ST_NCAND:  state_d = ST_NTEST;
      ST_NTEST: begin
        if (cnt_q == '0) state_d = (j_q == 2'd2) ? ST_IDLE : ST_NLOAD;
        else state_d = ST_NCAND;
      end
      default:   state_d = ST_IDLE;
    endcase
  end

  // Next state of the result sender; it starts on a flush or when a triangle finishes.
  logic start_emit;
  assign start_emit = (state_q == ST_IDLE && in_fire && held_q != 2'd2 && vtx_i.end_of_mesh)
                   || (state_q == ST_CHECK && s_q == '0)
                   || (state_q == ST_NTEST && cnt_q == '0 && j_q == 2'd2);

  always_comb begin
    ostate_d = ostate_q;
    case (ostate_q)
      OUT_IDLE: if (start_emit) ostate_d = OUT_BUSY;
      OUT_BUSY: if (out_fire && j_q == n_q - 2'd1) ostate_d = OUT_IDLE;
      default:  ostate_d = OUT_IDLE;
    endcase
  end

  // Handshake outputs.
  always_comb begin
    vtx_i.ready = (state_q == ST_IDLE) && (ostate_q == OUT_IDLE);
    res_o.valid = (ostate_q == OUT_BUSY);
  end

  assign res_o.out_x       = pos_q[j_q][0];
  assign res_o.out_y       = pos_q[j_q][1];
  assign res_o.out_z       = pos_q[j_q][2];
  assign res_o.out_f       = attr_q[j_q][0];
  assign res_o.out_u       = attr_q[j_q][1];
  assign res_o.out_v       = attr_q[j_q][2];
  assign res_o.normal_x    = nrm_q[0];
  assign res_o.normal_y    = nrm_q[1];
  assign res_o.normal_z    = nrm_q[2];
  assign res_o.degenerate  = deg_q;
  assign res_o.last_of_run = (j_q == n_q - 2'd1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      ostate_q <= OUT_IDLE;
      held_q   <= '0;
      cnt_q    <= '0;
      j_q      <= '0;
      n_q      <= '0;
      for (int v = 0; v < 3; v++) begin
        for (int i = 0; i < 3; i++) begin
          pos_q[v][i]  <= '0;
          attr_q[v][i] <= '0;
        end
      end
    end else begin
      state_q  <= state_d;
      ostate_q <= ostate_d;
      case (state_q)
        ST_IDLE: begin
          if (in_fire) begin
            pos_q[held_q][0]  <= vtx_i.pos_x;
            pos_q[held_q][1]  <= vtx_i.pos_y;
            pos_q[held_q][2]  <= vtx_i.pos_z;
            attr_q[held_q][0] <= vtx_i.pos_f;
            attr_q[held_q][1] <= vtx_i.tex_u;
            attr_q[held_q][2] <= vtx_i.tex_v;
            if (held_q == 2'd2) begin
              held_q <= '0;
              cnt_q  <= '0;
            end else if (vtx_i.end_of_mesh) begin
              // Flush of a partial triangle: one or two vertices, no normal.
              held_q <= '0;
              n_q    <= held_q + 2'd1;
              j_q    <= '0;
              deg_q  <= 1'b1;
              for (int i = 0; i < 3; i++) nrm_q[i] <= '0;
            end else begin
              held_q <= held_q + 2'd1;
            end
          end
        end
        ST_CROSS: begin
          if (cnt_q[0]) c_q[cnt_q[2:1]] <= c_q[cnt_q[2:1]] - CrossW'(prod);
          else c_q[cnt_q[2:1]] <= CrossW'(prod);
          if (cnt_q == CntW'(5)) begin
            j_q <= '0;
            s_q <= '0;
          end
          cnt_q <= cnt_q + CntW'(1);
        end
        ST_SQLOAD: begin
          mand_q <= SqW'(c_mag);
          mplr_q <= c_mag;
          acc_q  <= '0;
          cnt_q  <= '0;
        end
        ST_SQ: begin
          acc_q  <= acc_nxt;
          mand_q <= mand_q << 1;
          mplr_q <= mplr_q >> 1;
          cnt_q  <= cnt_q + CntW'(1);
          if (cnt_q == CntW'(MagW - 1)) begin
            csq_q[j_q] <= acc_nxt;
            s_q        <= s_q + SumW'(acc_nxt);
            j_q        <= (j_q == 2'd2) ? 2'd0 : j_q + 2'd1;
          end
        end
        ST_CHECK: begin
          n_q <= 2'd3;
          j_q <= '0;
          if (s_q == '0) begin
            deg_q <= 1'b1;
            for (int i = 0; i < 3; i++) nrm_q[i] <= '0;
          end else begin
            deg_q <= 1'b0;
          end
        end
        ST_NLOAD: begin
          // Bit by bit: keep q*q*S and q*S aligned so each step is one add and compare.
          p_q   <= '0;
          qs_q  <= '0;
          ss_q  <= WideW'(s_q) << (2 * NormFracBits);
          lim_q <= WideW'(csq_q[j_q]) << (2 * NormFracBits);
          quo_q <= '0;
          cnt_q <= CntW'(NormFracBits);
        end
        ST_NCAND: begin
          cand_q <= p_q + qs_q + ss_q;
        end
        ST_NTEST: begin
          if (cand_q <= lim_q) p_q <= cand_q;
          quo_q <= quo_set;
          qs_q  <= qs_add >> 1;
          ss_q  <= ss_q >> 2;
          if (cnt_q == '0) begin
            nrm_q[j_q] <= quo_fin[PosW-1:0];
            j_q        <= (j_q == 2'd2) ? 2'd0 : j_q + 2'd1;
          end else begin
            cnt_q <= cnt_q - CntW'(1);
          end
        end
        default: ;
      endcase
      if (ostate_q == OUT_BUSY && out_fire) begin
        j_q <= (j_q == n_q - 2'd1) ? 2'd0 : j_q + 2'd1;
      end
    end
  end

  a_ready_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vtx_i.ready |-> !res_o.valid) else $error("input ready while results pending");
  a_deg_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_o.valid && res_o.degenerate) |->
      (res_o.normal_x == '0 && res_o.normal_y == '0 && res_o.normal_z == '0))
    else $error("degenerate result with nonzero normal");
  a_held_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    held_q != 2'd3) else $error("held count out of range");
  a_norm_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_NLOAD) |-> (s_q != '0)) else $error("normalising a zero vector");
  a_emit_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_o.valid |-> (state_q == ST_IDLE)) else $error("emitting while computing");

endmodule
